// ===== rtl/core/kwm_pkg.sv =====
// Shared types and constants for the k-way merge by date key.
// Holds the channel words, the record and pointer layouts, the operation and
// status codes and the command and status structs between controller and datapath.
package kwm_pkg;

	localparam int NUM_RUNS  = 64;
	localparam int RUN_DEPTH = 256;

	localparam int RUN_W     = $clog2(NUM_RUNS);
	localparam int DEPTH_W   = $clog2(RUN_DEPTH);
	localparam int PTR_W     = $clog2(RUN_DEPTH + 1);
	localparam int REC_AW    = RUN_W + DEPTH_W;
	localparam int REC_DEPTH = NUM_RUNS * RUN_DEPTH;

	localparam int CHECK_MOD = 167;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_POPPED   = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  run_index;
		logic [53:0] date_key;
		logic [7:0]  check_value;
		logic [31:0] payload;
	} item_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  out_run;
		logic [53:0] out_key;
		logic [7:0]  out_check;
		logic [31:0] out_payload;
		logic [7:0]  check_sum;
		logic [14:0] emitted_count;
	} result_word_t;

	typedef struct packed {
		logic [53:0] key;
		logic [7:0]  check;
		logic [31:0] payload;
	} rec_t;

	typedef struct packed {
		logic [PTR_W-1:0] rp;
		logic [PTR_W-1:0] wp;
	} ptr_t;

	typedef struct packed {
		logic accept;
		logic scan_start;
		logic scan_issue;
		logic load_commit;
		logic pop_commit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic scan_last;
	} sts_t;

endpackage

// ===== rtl/core/k_way_merge_by_date.sv =====
// Top level of the k-way merge by date key.
// Joins kwm_ctrl and kwm_dpath; channel words are types from kwm_pkg.
//
//   channel  direction  handshake                  word
//   item     in         item_valid / item_stall    kwm_pkg::item_word_t
//   result   out        result_valid / result_stall kwm_pkg::result_word_t
//
// A load goes through LD_RD and LD_WR to the result register; a clear through CLR.
// A pop reads the head of every run once through the single pointer memory read port
// and the single record memory read port, with one comparator, in a three-stage scan
// pipeline.
// Reset clears all run pointers at once through per-run valid bits; no clearing pass.
// One item is worked at a time; the next is taken while a result waits in the
// output register, and a held result stalls the next item just before its result step.
module k_way_merge_by_date (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  kwm_pkg::item_word_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output kwm_pkg::result_word_t result
);

	kwm_pkg::cmd_t cmd;
	kwm_pkg::sts_t sts;

	kwm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.operation  (item.operation),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	kwm_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/core/kwm_ctrl.sv =====
// Controller state machine for the k-way merge by date key.
// Sequences load, pop scan and clear; depends on kwm_pkg for codes and the
// command and status structs.
module kwm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic [1:0]    operation,
	output logic          item_stall,
	output kwm_pkg::cmd_t cmd,
	input  kwm_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		IDLE,
		LD_RD,
		LD_WR,
		SCAN,
		DRAIN1,
		DRAIN2,
		POP_FIN,
		CLR
	} state_t;

	state_t state_q;
	logic   accept;

	assign item_stall = (state_q != IDLE);
	assign accept     = item_valid && (state_q == IDLE);

	always_comb begin
		cmd             = '0;
		cmd.accept      = accept;
		cmd.scan_start  = accept && (operation == kwm_pkg::OP_POP);
		cmd.scan_issue  = (state_q == SCAN);
		cmd.load_commit = (state_q == LD_WR);
		cmd.pop_commit  = (state_q == POP_FIN);
		cmd.clear       = (state_q == CLR) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						priority if (operation == kwm_pkg::OP_LOAD) begin
							state_q <= LD_RD;
						end else if (operation == kwm_pkg::OP_POP) begin
							state_q <= SCAN;
						end else if (operation == kwm_pkg::OP_CLEAR) begin
							state_q <= CLR;
						end else begin
							state_q <= IDLE;
						end
					end
				end
				LD_RD: begin
					if (sts.out_free) begin
						state_q <= LD_WR;
					end
				end
				LD_WR: begin
					state_q <= IDLE;
				end
				SCAN: begin
					if (sts.scan_last) begin
						state_q <= DRAIN1;
					end
				end
				DRAIN1: begin
					state_q <= DRAIN2;
				end
				DRAIN2: begin
					if (sts.out_free) begin
						state_q <= POP_FIN;
					end
				end
				POP_FIN: begin
					state_q <= IDLE;
				end
				CLR: begin
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	ap_scan_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN) && sts.scan_last |=> (state_q == DRAIN1))
		else $error("scan did not drain after its last run");

	ap_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_commit || cmd.pop_commit || cmd.clear) |-> sts.out_free)
		else $error("result produced while the output register is occupied");

	ap_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && (operation == kwm_pkg::OP_LOAD || operation == kwm_pkg::OP_POP
			|| operation == kwm_pkg::OP_CLEAR) |=> item_stall)
		else $error("controller left idle without stalling the input");

endmodule

// ===== rtl/core/kwm_dpath.sv =====
// Datapath for the k-way merge by date key: record store, run pointers,
// pipelined head scan, check sum, count and the output register.
// Depends on kwm_pkg; driven by kwm_ctrl through cmd_t and sts_t.
module kwm_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kwm_pkg::item_word_t   item,
	input  kwm_pkg::cmd_t         cmd,
	output kwm_pkg::sts_t         sts,
	output logic                  result_valid,
	input  logic                  result_stall,
	output kwm_pkg::result_word_t result
);

	kwm_pkg::item_word_t item_q;

	kwm_pkg::rec_t rec_mem [kwm_pkg::REC_DEPTH];
	kwm_pkg::ptr_t ptr_mem [kwm_pkg::NUM_RUNS];
	logic [kwm_pkg::NUM_RUNS-1:0] vld_q;

	logic [kwm_pkg::RUN_W-1:0]  scan_q;
	logic [kwm_pkg::RUN_W-1:0]  ptr_raddr;
	logic [kwm_pkg::RUN_W-1:0]  item_run;

	kwm_pkg::ptr_t              ptr_rd_s1;
	logic                       pv_s1;
	logic                       act_s1;
	logic [kwm_pkg::RUN_W-1:0]  run_s1;
	kwm_pkg::ptr_t              eff_ptr;
	logic [kwm_pkg::REC_AW-1:0] rec_raddr;

	kwm_pkg::rec_t              rec_rd_s2;
	logic                       ne_s2;
	logic                       act_s2;
	logic [kwm_pkg::RUN_W-1:0]  run_s2;
	kwm_pkg::ptr_t              ptr_s2;

	logic                       found_q;
	logic [kwm_pkg::RUN_W-1:0]  best_run_q;
	kwm_pkg::ptr_t              best_ptr_q;
	kwm_pkg::rec_t              best_rec_q;

	logic [7:0]                 sum_q;
	logic [14:0]                count_q;
	logic [8:0]                 sum_raw;
	logic [7:0]                 sum_next;

	logic                       run_ok;
	logic                       load_ok;
	logic                       rec_we;
	logic                       ptr_we;
	logic [kwm_pkg::RUN_W-1:0]  ptr_waddr;
	kwm_pkg::ptr_t              ptr_wdata;
	logic                       capture;

	logic                       out_valid_q;
	kwm_pkg::result_word_t      out_q;
	kwm_pkg::result_word_t      out_d;

	assign item_run  = kwm_pkg::RUN_W'(item_q.run_index);
	assign ptr_raddr = cmd.scan_issue ? scan_q : item_run;
	assign eff_ptr   = pv_s1 ? ptr_rd_s1 : '0;
	assign rec_raddr = {run_s1, eff_ptr.rp[kwm_pkg::DEPTH_W-1:0]};

	assign run_ok  = int'(item_q.run_index) < kwm_pkg::NUM_RUNS;
	assign load_ok = run_ok && (eff_ptr.wp < kwm_pkg::PTR_W'(kwm_pkg::RUN_DEPTH));
	assign rec_we  = cmd.load_commit && load_ok;

	always_comb begin
		ptr_we    = 1'b0;
		ptr_waddr = item_run;
		ptr_wdata = eff_ptr;
		if (rec_we) begin
			ptr_we       = 1'b1;
			ptr_wdata.wp = eff_ptr.wp + kwm_pkg::PTR_W'(1);
		end else if (cmd.pop_commit && found_q) begin
			ptr_we       = 1'b1;
			ptr_waddr    = best_run_q;
			ptr_wdata    = best_ptr_q;
			ptr_wdata.rp = best_ptr_q.rp + kwm_pkg::PTR_W'(1);
		end
	end

	assign sum_raw = {1'b0, sum_q} + {1'b0, best_rec_q.check};
	always_comb begin
		priority if (sum_raw >= 9'(2 * kwm_pkg::CHECK_MOD)) begin
			sum_next = 8'(sum_raw - 9'(2 * kwm_pkg::CHECK_MOD));
		end else if (sum_raw >= 9'(kwm_pkg::CHECK_MOD)) begin
			sum_next = 8'(sum_raw - 9'(kwm_pkg::CHECK_MOD));
		end else begin
			sum_next = sum_raw[7:0];
		end
	end

	always_comb begin
		out_d               = '0;
		out_d.check_sum     = sum_q;
		out_d.emitted_count = count_q;
		priority if (cmd.clear) begin
			out_d.status        = kwm_pkg::ST_CLEARED;
			out_d.check_sum     = '0;
			out_d.emitted_count = '0;
		end else if (cmd.load_commit) begin
			out_d.status = load_ok ? kwm_pkg::ST_LOADED : kwm_pkg::ST_OVERFLOW;
		end else if (found_q) begin
			out_d.status        = kwm_pkg::ST_POPPED;
			out_d.out_run       = 6'(best_run_q);
			out_d.out_key       = best_rec_q.key;
			out_d.out_check     = best_rec_q.check;
			out_d.out_payload   = best_rec_q.payload;
			out_d.check_sum     = sum_next;
			out_d.emitted_count = count_q + 15'd1;
		end else begin
			out_d.status = kwm_pkg::ST_EMPTY;
		end
	end

	assign capture       = cmd.load_commit || cmd.pop_commit || cmd.clear;
	assign sts.out_free  = !out_valid_q || !result_stall;
	assign sts.scan_last = (scan_q == kwm_pkg::RUN_W'(kwm_pkg::NUM_RUNS - 1));
	assign result_valid  = out_valid_q;
	assign result        = out_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (rec_we) begin
			rec_mem[{item_run, eff_ptr.wp[kwm_pkg::DEPTH_W-1:0]}] <=
				'{key: item_q.date_key, check: item_q.check_value, payload: item_q.payload};
		end
		rec_rd_s2 <= rec_mem[rec_raddr];
		if (ptr_we) begin
			ptr_mem[ptr_waddr] <= ptr_wdata;
		end
		ptr_rd_s1 <= ptr_mem[ptr_raddr];
		pv_s1     <= vld_q[ptr_raddr];
		run_s1    <= ptr_raddr;
		ne_s2     <= eff_ptr.rp < eff_ptr.wp;
		run_s2    <= run_s1;
		ptr_s2    <= eff_ptr;
		if (act_s2 && ne_s2 && (!found_q || (rec_rd_s2.key < best_rec_q.key))) begin
			best_run_q <= run_s2;
			best_ptr_q <= ptr_s2;
			best_rec_q <= rec_rd_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			scan_q      <= '0;
			act_s1      <= 1'b0;
			act_s2      <= 1'b0;
			found_q     <= 1'b0;
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			act_s1 <= cmd.scan_issue;
			act_s2 <= act_s1;
			if (cmd.scan_start) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					scan_q <= scan_q + kwm_pkg::RUN_W'(1);
				end
				if (act_s2 && ne_s2) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (ptr_we) begin
				vld_q[ptr_waddr] <= 1'b1;
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (cmd.pop_commit && found_q) begin
				sum_q   <= sum_next;
				count_q <= count_q + 15'd1;
			end
			if (capture) begin
				out_q <= out_d;
			end
		end
	end

	ap_best_live: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_ptr_q.rp < best_ptr_q.wp))
		else $error("chosen run head lies beyond its write pointer");

	ap_capture_shows: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> out_valid_q)
		else $error("captured result not presented");

	ap_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> !act_s1 && !act_s2 && !cmd.scan_issue)
		else $error("record written while a scan is in flight");

	ap_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_commit && found_q |=> (sum_q < 8'(kwm_pkg::CHECK_MOD)))
		else $error("check sum left its modulo range");

endmodule
